### hdl/uer_pkg.sv
// shared types, register codes and scaling constants for the echo ranger
package uer_pkg;

  localparam int ECHO_COUNT_BITS_DEF = 17;

  localparam int PERIOD_W = 18;
  localparam int TRIG_W   = 8;
  localparam int HALF_W   = 16;
  localparam int DIST_W   = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HALF_DELAY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_LIMIT_MM = 8'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_TICKS_RST   = 18'd150000;
  localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RST  = 8'd12;
  localparam logic [HALF_W-1:0]   MAX_HALF_DELAY_RST = 16'd20000;
  localparam logic [DIST_W-1:0]   VALID_LIMIT_MM_RST = 15'd3500;

  // 0.343 mm per microsecond: multiply by 343, then divide by 1000
  localparam int SOUND_W = 9;
  localparam logic [SOUND_W-1:0] SOUND_MM_PER_KUS = 9'd343;
  localparam int PROD_W = HALF_W + SOUND_W;
  // floor(p / 1000) = (p * ceil(2^35 / 1000)) >> 35, exact for p below 2^25
  localparam int RECIP_W = 26;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 26'd34359739;
  localparam int SCALED_W = PROD_W + RECIP_W;

  typedef struct packed {
    logic [DIST_W-1:0]   valid_limit_mm;
    logic [HALF_W-1:0]   max_half_delay;
    logic [TRIG_W-1:0]   trigger_ticks;
    logic [PERIOD_W-1:0] period_ticks;
  } cfg_t;

  typedef struct packed {
    logic              trig;
    logic              upd;
    logic [HALF_W-1:0] half;
  } tick_res_t;

  typedef struct packed {
    logic              trig;
    logic              upd;
    logic [DIST_W-1:0] mm;
  } scaled_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic              updated;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_mm;
    logic              trigger_out;
  } result_t;

endpackage

### hdl/uer_tick.sv
// per-tick timing: period counter, trigger pulse and echo width capture
module uer_tick #(
  parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  uer_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              echo,
  output logic              out_valid,
  input  logic              out_ready,
  output uer_pkg::tick_res_t out_res
);

  localparam int HW_RAW = ECHO_COUNT_BITS - 1;
  localparam int CMP_W = (HW_RAW > uer_pkg::HALF_W) ? HW_RAW : uer_pkg::HALF_W;

  logic [uer_pkg::PERIOD_W-1:0] period_count, period_count_next, pc_inc;
  logic [uer_pkg::TRIG_W-1:0]   pulse_count, pulse_count_next, pulse_mid;
  logic                         echo_prev;
  logic [ECHO_COUNT_BITS-1:0]   echo_width, echo_width_next;
  logic                         measure_done, measure_done_next;
  logic                         due, upd, trig;
  logic [CMP_W-1:0]             half_ext, limit_ext;
  logic [uer_pkg::HALF_W-1:0]   half_cl;
  logic                         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    half_ext  = CMP_W'(echo_width >> 1);
    limit_ext = CMP_W'(cfg.max_half_delay);
    half_cl   = (half_ext > limit_ext) ? cfg.max_half_delay
                                       : half_ext[uer_pkg::HALF_W-1:0];
  end

  always_comb begin
    pc_inc = (period_count != '1) ? period_count + 1'b1 : period_count;
    due = (pc_inc >= cfg.period_ticks);
    upd = 1'b0;
    period_count_next = pc_inc;
    pulse_mid = pulse_count;
    echo_width_next = echo_width;
    measure_done_next = measure_done;
    if (due) begin
      period_count_next = '0;
      measure_done_next = 1'b0;
      echo_width_next = '0;
      pulse_mid = cfg.trigger_ticks;
    end else if (measure_done) begin
      measure_done_next = 1'b0;
      upd = 1'b1;
    end
    // edge capture
    if (!measure_done_next) begin
      if (echo && !echo_prev) begin
        echo_width_next = ECHO_COUNT_BITS'(1);
      end else if (echo && echo_prev) begin
        if (echo_width_next != '1) begin
          echo_width_next = echo_width_next + 1'b1;
        end
      end else if (!echo && echo_prev) begin
        measure_done_next = 1'b1;
      end
    end
    trig = (pulse_mid != '0);
    pulse_count_next = trig ? pulse_mid - 1'b1 : pulse_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      pulse_count  <= '0;
      echo_prev    <= 1'b0;
      echo_width   <= '0;
      measure_done <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        period_count <= period_count_next;
        pulse_count  <= pulse_count_next;
        echo_prev    <= echo;
        echo_width   <= echo_width_next;
        measure_done <= measure_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res.trig <= trig;
      out_res.upd  <= upd;
      out_res.half <= half_cl;
    end
  end

endmodule

### hdl/uer_scale.sv
// delay to millimetres: multiply by 343, then reciprocal multiply for /1000
module uer_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  uer_pkg::tick_res_t  in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output uer_pkg::scaled_t    out_res
);

  logic                         v2, v3, rdy3;
  logic                         trig2, upd2, trig3, upd3;
  logic [uer_pkg::PROD_W-1:0]   prod;
  logic [uer_pkg::SCALED_W-1:0] scaled;

  assign rdy3     = !v3 || out_ready;
  assign in_ready = !v2 || rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) begin
        v2 <= in_valid;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      trig2 <= in_res.trig;
      upd2  <= in_res.upd;
      prod  <= uer_pkg::PROD_W'(in_res.half) * uer_pkg::PROD_W'(uer_pkg::SOUND_MM_PER_KUS);
    end
    if (rdy3 && v2) begin
      trig3  <= trig2;
      upd3   <= upd2;
      scaled <= uer_pkg::SCALED_W'(prod) * uer_pkg::SCALED_W'(uer_pkg::RECIP_MULT);
    end
  end

  assign out_valid    = v3;
  assign out_res.trig = trig3;
  assign out_res.upd  = upd3;
  assign out_res.mm   =
    scaled[uer_pkg::RECIP_SHIFT + uer_pkg::DIST_W - 1 : uer_pkg::RECIP_SHIFT];

endmodule

### hdl/uer_out.sv
// distance hold, limit check and output register
module uer_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [uer_pkg::DIST_W-1:0]     valid_limit_mm,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  uer_pkg::scaled_t               in_res,
  output logic                           out_valid,
  input  logic                           out_ready,
  output uer_pkg::result_t               out_res
);

  logic [uer_pkg::DIST_W-1:0] distance_reg, dist_sel;
  logic                       ok;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dist_sel = in_res.upd ? in_res.mm : distance_reg;
    ok       = (dist_sel < valid_limit_mm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      distance_reg <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (in_ready && in_valid && in_res.upd) begin
        distance_reg <= in_res.mm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res.pad            <= '0;
      out_res.updated        <= in_res.upd;
      out_res.distance_valid <= ok;
      out_res.distance_mm    <= ok ? dist_sel : '0;
      out_res.trigger_out    <= in_res.trig;
    end
  end

endmodule

### hdl/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo ranger
// Each request on the slave stream is one microsecond tick carrying the sampled
// echo level, and gives exactly one result: trigger drive, last distance in mm
// (0 when not below the limit), its valid flag and an updated flag. A new tick
// is taken every clock cycle unless back pressure stalls it; a result reaches
// the master side through the tick register, the two multiplier stages of the
// mm scaling (x343, then a reciprocal multiply for /1000) and the output
// register, the tick register loading at the edge that takes its tick.
// Back pressure on the master side stalls the whole pipeline. The config port
// is always ready and should be written only while no ticks are in flight.
module ultrasonic_echo_ranger #(
  parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] echo_level
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] trigger_out, [15:1] distance_mm, [16] distance_valid, [17] updated
  output logic [23:0]                       m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

  uer_pkg::cfg_t      cfg;
  uer_pkg::tick_res_t tick_res;
  uer_pkg::scaled_t   scaled_res;
  uer_pkg::result_t   result;
  logic               tick_valid, tick_ready, scaled_valid, scaled_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks   <= uer_pkg::PERIOD_TICKS_RST;
      cfg.trigger_ticks  <= uer_pkg::TRIGGER_TICKS_RST;
      cfg.max_half_delay <= uer_pkg::MAX_HALF_DELAY_RST;
      cfg.valid_limit_mm <= uer_pkg::VALID_LIMIT_MM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uer_pkg::REG_PERIOD_TICKS: begin
          cfg.period_ticks <= cfg_data[uer_pkg::PERIOD_W-1:0];
        end
        uer_pkg::REG_TRIGGER_TICKS: begin
          cfg.trigger_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
        end
        uer_pkg::REG_MAX_HALF_DELAY: begin
          cfg.max_half_delay <= cfg_data[uer_pkg::HALF_W-1:0];
        end
        uer_pkg::REG_VALID_LIMIT_MM: begin
          cfg.valid_limit_mm <= cfg_data[uer_pkg::DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  uer_tick #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_tick (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .echo      (s_tdata[0]),
    .out_valid (tick_valid),
    .out_ready (tick_ready),
    .out_res   (tick_res)
  );

  uer_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick_valid),
    .in_ready  (tick_ready),
    .in_res    (tick_res),
    .out_valid (scaled_valid),
    .out_ready (scaled_ready),
    .out_res   (scaled_res)
  );

  uer_out u_out (
    .clk            (clk),
    .rst            (rst),
    .valid_limit_mm (cfg.valid_limit_mm),
    .in_valid       (scaled_valid),
    .in_ready       (scaled_ready),
    .in_res         (scaled_res),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_res        (result)
  );

  assign m_tdata = result;

  // an empty pipeline must never hold back the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !tick_valid && !scaled_valid |-> s_tready)
    else $error("input stalled with empty pipeline");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result.distance_valid |-> result.distance_mm == '0)
    else $error("invalid distance not reported as zero");

  a_valid_below_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.distance_valid |-> result.distance_mm < cfg.valid_limit_mm)
    else $error("valid distance at or above limit");

endmodule

### bench/tb_ultrasonic_echo_ranger.sv
// self-checking stream testbench for the ultrasonic echo ranger
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;

  localparam int EW = uer_pkg::ECHO_COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_TICK_GOAL = 1450;
  localparam int DRAIN_PAD = 8;
  localparam int unsigned MM_DIVISOR = 1000;
  localparam logic [uer_pkg::PERIOD_W-1:0] PERIOD_SAT = '1;

  typedef struct {
    bit                      trig;
    bit [uer_pkg::DIST_W-1:0] mm;
    bit                      valid;
    bit                      upd;
  } tick_result_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    bit                              echo;
    logic [uer_pkg::CFG_IDX_W-1:0]   idx;
    logic [uer_pkg::CFG_DATA_W-1:0]  data;
    bit                              typed;
    tick_result_t                    res;
  } stim_row_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [23:0]                      m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // ranging state mirrored by the predictor
  logic [uer_pkg::PERIOD_W-1:0] cfg_period;
  logic [uer_pkg::TRIG_W-1:0]   cfg_trig;
  logic [uer_pkg::HALF_W-1:0]   cfg_half_max;
  logic [uer_pkg::DIST_W-1:0]   cfg_limit;
  logic [uer_pkg::PERIOD_W-1:0] per_cnt;
  logic [uer_pkg::TRIG_W-1:0]   pulse_left;
  logic                         echo_last;
  logic [EW-1:0]                hi_width;
  logic                         meas_done;
  logic [uer_pkg::DIST_W-1:0]   dist_q;

  tick_result_t expected_readings[$];
  stim_row_t    stim_rows[$];
  tick_result_t no_typed;
  bit           idle_on = 1'b1;
  int           errors = 0;
  int           results_seen = 0;
  int           random_ticks = 0;
  int           cycle_count = 0;

  ultrasonic_echo_ranger #(
    .ECHO_COUNT_BITS(EW)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ultrasonic_echo_ranger regression: fail");
      $finish;
    end
  end

  function automatic void apply_register(logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                         logic [uer_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      uer_pkg::REG_PERIOD_TICKS:   cfg_period   = data[uer_pkg::PERIOD_W-1:0];
      uer_pkg::REG_TRIGGER_TICKS:  cfg_trig     = data[uer_pkg::TRIG_W-1:0];
      uer_pkg::REG_MAX_HALF_DELAY: cfg_half_max = data[uer_pkg::HALF_W-1:0];
      uer_pkg::REG_VALID_LIMIT_MM: cfg_limit    = data[uer_pkg::DIST_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic tick_result_t compute_ranging(bit echo);
    tick_result_t r;
    int unsigned half;
    bit fresh;
    fresh = 1'b0;
    if (per_cnt != PERIOD_SAT) per_cnt++;
    if (per_cnt >= cfg_period) begin
      per_cnt = '0;
      meas_done = 1'b0;
      hi_width = '0;
      pulse_left = cfg_trig;
    end else if (meas_done) begin
      meas_done = 1'b0;
      half = hi_width >> 1;
      if (half > cfg_half_max) half = cfg_half_max;
      dist_q = uer_pkg::DIST_W'((half * uer_pkg::SOUND_MM_PER_KUS) / MM_DIVISOR);
      fresh = 1'b1;
    end
    if (!meas_done) begin
      if (echo && !echo_last) begin
        hi_width = 1;
      end else if (echo && echo_last) begin
        if (hi_width != '1) hi_width++;
      end else if (!echo && echo_last) begin
        meas_done = 1'b1;
      end
    end
    echo_last = echo;
    r.trig = (pulse_left != 0);
    if (r.trig) pulse_left--;
    r.valid = (dist_q < cfg_limit);
    r.mm = r.valid ? dist_q : '0;
    r.upd = fresh;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch on result %0d, %s: expected %0d, got %0d",
             results_seen, what, want, got);
    errors++;
  endtask

  task automatic check_reading(logic [23:0] data);
    uer_pkg::result_t got;
    tick_result_t want;
    got = data;
    results_seen++;
    if (expected_readings.size() == 0) begin
      report_mismatch("result with no request pending", 0, 1);
    end else begin
      want = expected_readings.pop_front();
      if (got.trigger_out !== want.trig)
        report_mismatch("trigger_out", want.trig, got.trigger_out);
      if (got.distance_mm !== want.mm)
        report_mismatch("distance_mm", want.mm, got.distance_mm);
      if (got.distance_valid !== want.valid)
        report_mismatch("distance_valid", want.valid, got.distance_valid);
      if (got.updated !== want.upd)
        report_mismatch("updated", want.upd, got.updated);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_reading(m_tdata);
  end

  // result side: random stall before each result while idle_on is set
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_echo_tick(bit echo, bit typed, tick_result_t typed_res);
    int gap;
    tick_result_t predicted;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, echo};
    do @(posedge clk); while (!s_tready);
    predicted = compute_ranging(echo);
    expected_readings.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes do not toggle it
  task automatic write_register(logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                logic [uer_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic configure_ranger(logic [31:0] period, logic [31:0] trig,
                                  logic [31:0] half, logic [31:0] limit);
    write_register(uer_pkg::REG_PERIOD_TICKS, period);
    write_register(uer_pkg::REG_TRIGGER_TICKS, trig);
    write_register(uer_pkg::REG_MAX_HALF_DELAY, half);
    write_register(uer_pkg::REG_VALID_LIMIT_MM, limit);
    if ($urandom_range(0, 3) == 0)
      write_register(uer_pkg::CFG_IDX_W'($urandom_range(4, 255)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // random upper bits above the register width, now and then
  function automatic logic [31:0] widen(int unsigned value, int unsigned w);
    logic [31:0] v;
    v = value;
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << w);
    return v;
  endfunction

  task automatic add_tick(bit echo);
    stim_row_t r;
    r.kind = ROW_TICK;
    r.echo = echo;
    r.idx = '0;
    r.data = '0;
    r.typed = 1'b0;
    r.res = no_typed;
    stim_rows.push_back(r);
  endtask

  task automatic add_typed(bit echo, bit trig, int unsigned mm, bit valid, bit upd);
    stim_row_t r;
    r.kind = ROW_TICK;
    r.echo = echo;
    r.idx = '0;
    r.data = '0;
    r.typed = 1'b1;
    r.res.trig = trig;
    r.res.mm = mm;
    r.res.valid = valid;
    r.res.upd = upd;
    stim_rows.push_back(r);
  endtask

  task automatic add_write(logic [uer_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.echo = 1'b0;
    r.idx = idx;
    r.data = data;
    r.typed = 1'b0;
    r.res = no_typed;
    stim_rows.push_back(r);
  endtask

  initial begin
    bit level;
    int run_left;
    int phase_len;
    int hold_point;
    logic [31:0] period, trig, half, limit;
    bit [15:0] pattern;

    no_typed = '{default: 0};
    cfg_period = uer_pkg::PERIOD_TICKS_RST;
    cfg_trig = uer_pkg::TRIGGER_TICKS_RST;
    cfg_half_max = uer_pkg::MAX_HALF_DELAY_RST;
    cfg_limit = uer_pkg::VALID_LIMIT_MM_RST;
    per_cnt = '0;
    pulse_left = '0;
    echo_last = 1'b0;
    hi_width = '0;
    meas_done = 1'b0;
    dist_q = '0;

    // directed table
    add_typed(1'b0, 1'b0, 0, 1'b1, 1'b0);
    add_write(uer_pkg::REG_PERIOD_TICKS, 32'hFFFC_0000);
    add_write(uer_pkg::REG_TRIGGER_TICKS, 32'd255);
    add_typed(1'b1, 1'b1, 0, 1'b1, 1'b0);
    add_typed(1'b0, 1'b1, 0, 1'b1, 1'b0);
    add_write(uer_pkg::REG_TRIGGER_TICKS, 32'hFFFF_FF00);
    add_typed(1'b1, 1'b0, 0, 1'b1, 1'b0);
    add_write(uer_pkg::REG_VALID_LIMIT_MM, 32'd0);
    add_typed(1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_write(8'h5A, 32'h0000_1234);
    add_write(uer_pkg::REG_PERIOD_TICKS, 32'd40);
    add_write(uer_pkg::REG_TRIGGER_TICKS, 32'd3);
    add_write(uer_pkg::REG_MAX_HALF_DELAY, 32'd65535);
    add_write(uer_pkg::REG_VALID_LIMIT_MM, 32'd22478);
    // long pulse, then edges arriving while a measurement is pending
    pattern = 16'b0110_1011_1000_1111;
    add_tick(1'b0);
    for (int i = 0; i < 16; i++) add_tick(pattern[i]);
    add_tick(1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_CFG: begin
          wait_drained();
          write_register(stim_rows[i].idx, stim_rows[i].data);
          cfg_valid <= 1'b0;
        end
        default: begin
          send_echo_tick(stim_rows[i].echo, stim_rows[i].typed, stim_rows[i].res);
        end
      endcase
    end

    // delay clamp, distance exactly at the limit, then just below it
    wait_drained();
    configure_ranger(32'd262143, 32'd1, 32'd100, 32'd34);
    idle_on = 1'b0;
    send_echo_tick(1'b0, 1'b0, no_typed);
    repeat (300) send_echo_tick(1'b1, 1'b0, no_typed);
    repeat (3) send_echo_tick(1'b0, 1'b0, no_typed);
    wait_drained();
    write_register(uer_pkg::REG_VALID_LIMIT_MM, 32'd35);
    cfg_valid <= 1'b0;
    repeat (2) send_echo_tick(1'b0, 1'b0, no_typed);

    // random phases of echo pulses under random settings
    while (random_ticks < RANDOM_TICK_GOAL) begin
      wait_drained();
      case ($urandom_range(0, 7))
        0: period = 1;
        1: period = 0;
        2, 3: period = $urandom_range(65, 3000);
        default: period = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 5))
        0: trig = 0;
        1: trig = 255;
        default: trig = $urandom_range(1, 20);
      endcase
      case ($urandom_range(0, 4))
        0: half = 0;
        1: half = 65535;
        2: half = $urandom_range(0, 65535);
        default: half = $urandom_range(1, 300);
      endcase
      case ($urandom_range(0, 5))
        0: limit = 0;
        1: limit = 22478;
        2: limit = 32767;
        default: limit = $urandom_range(0, 150);
      endcase
      configure_ranger(widen(period, uer_pkg::PERIOD_W), widen(trig, uer_pkg::TRIG_W),
                       widen(half, uer_pkg::HALF_W), widen(limit, uer_pkg::DIST_W));
      idle_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(150, 350);
      hold_point = $urandom_range(0, phase_len - 1);
      level = 1'b1;
      run_left = 0;
      for (int n = 0; n < phase_len; n++) begin
        if (run_left == 0) begin
          level = ~level;
          case ($urandom_range(0, 7))
            0: run_left = 1;
            1: run_left = $urandom_range(100, 1500);
            default: run_left = $urandom_range(2, 40);
          endcase
        end
        if (n == hold_point) wait_drained();
        send_echo_tick(level, 1'b0, no_typed);
        run_left--;
        random_ticks++;
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger regression: pass");
    end else begin
      $display("ultrasonic_echo_ranger regression: fail");
    end
    $finish;
  end

endmodule

### ultrasonic_echo_ranger.f
hdl/uer_pkg.sv
hdl/uer_tick.sv
hdl/uer_scale.sv
hdl/uer_out.sv
hdl/ultrasonic_echo_ranger.sv
bench/tb_ultrasonic_echo_ranger.sv
